// File: src/sdg_pkg.sv
package sdg_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int TIMER_WIDTH_DEF = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int PROD_W          = 64;
	localparam int CARRY_W         = 17;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_STEPS = 2'd1;
	localparam logic [1:0] OP_ANGLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPR      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BURST    = 2'd3;

	localparam logic [31:0] INTERVAL_RST = 32'd100;
	localparam logic [31:0] SPR_RST      = 32'd2086059;
	localparam logic [4:0]  MODE_RST     = 5'd1;
	localparam logic [7:0]  BURST_RST    = 8'd1;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] step_delta;
		logic signed [31:0] angle_q16;
	} in_t;

	typedef struct packed {
		logic [7:0]         pulses;
		logic               dir_positive;
		logic signed [31:0] pending_steps;
		logic [2:0]         mode_pins;
	} out_t;

	typedef struct packed {
		logic [31:0] interval_ticks;
		logic [31:0] steps_per_radian;
		logic [4:0]  microstep_mode;
		logic [7:0]  burst_limit;
	} cfg_t;

	// word between the multiplier stage and the state update
	typedef struct packed {
		logic [1:0]                op;
		logic signed [31:0]        step_delta;
		logic signed [PROD_W-1:0]  prod;
	} mid_t;

	function automatic logic [2:0] decode_mode(input logic [4:0] m);
		logic [2:0] r;
		case (m)
			5'd1:    r = 3'd0;
			5'd2:    r = 3'd1;
			5'd4:    r = 3'd2;
			5'd8:    r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

endpackage

// File: src/sdg_cfg.sv
module sdg_cfg import sdg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ticks   <= INTERVAL_RST;
			cfg_q.steps_per_radian <= SPR_RST;
			cfg_q.microstep_mode   <= MODE_RST;
			cfg_q.burst_limit      <= BURST_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INTERVAL: cfg_q.interval_ticks   <= cfg_data;
				REG_SPR:      cfg_q.steps_per_radian <= cfg_data;
				REG_MODE:     cfg_q.microstep_mode   <= cfg_data[4:0];
				REG_BURST:    cfg_q.burst_limit      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// File: src/sdg_mult.sv
module sdg_mult import sdg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	input  logic [31:0] steps_per_radian,
	input  logic        mid_take,
	output logic        mid_valid,
	output mid_t        mid
);

	logic                    v_s1, v_s2;
	in_t                     in_s1;
	mid_t                    mid_s2;
	logic                    s1_en, s2_en;
	logic signed [PROD_W:0]  prod_full;

	assign s2_en    = !v_s2 || mid_take;
	assign s1_en    = !v_s1 || s2_en;
	assign in_ready = s1_en;

	// signed angle times unsigned Q16.16 gain
	assign prod_full = in_s1.angle_q16 * $signed({1'b0, steps_per_radian});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_en)
				v_s1 <= in_valid;
			if (s2_en)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && in_valid)
			in_s1 <= in_data;
		if (s2_en && v_s1) begin
			mid_s2.op         <= in_s1.op;
			mid_s2.step_delta <= in_s1.step_delta;
			mid_s2.prod       <= prod_full[PROD_W-1:0];
		end
	end

	assign mid_valid = v_s2;
	assign mid       = mid_s2;

endmodule

// File: src/sdg_core.sv
module sdg_core import sdg_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic mid_valid,
	input  mid_t mid,
	output logic mid_take,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int SW = ((COUNT_WIDTH > 33) ? COUNT_WIDTH : 33) + 1;
	localparam int LW = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;

	logic signed [COUNT_WIDTH-1:0] pending_q, pending_d, pending_tick, pending_sat;
	logic signed [CARRY_W-1:0]     carry_q, carry_d;
	logic                          dir_q, dir_d;
	logic [TIMER_WIDTH-1:0]        elapsed_q, elapsed_d, el_inc;
	logic                          out_valid_q;
	out_t                          out_q;
	logic [7:0]                    pulses_d;

	logic signed [PROD_W-1:0]      prod_adj;
	logic signed [47:0]            prod_q16;
	logic signed [48:0]            total, total_adj, rem;
	logic signed [32:0]            whole;

	logic signed [SW-1:0]          pend_x, addend, sum, sat_hi, sat_lo;
	logic [COUNT_WIDTH-1:0]        mag;
	logic [7:0]                    burst, k;
	logic                          due;
	logic signed [63:0]            pend64;

	assign mid_take = mid_valid && (!out_valid_q || out_ready);

	// angle: truncate product toward zero to Q16, add carry, split whole/fraction
	assign prod_adj  = mid.prod + $signed({48'd0, {16{mid.prod[PROD_W-1]}}});
	assign prod_q16  = prod_adj[63:16];
	assign total     = 49'(prod_q16) + 49'(carry_q);
	assign total_adj = total + $signed({33'd0, {16{total[48]}}});
	assign whole     = total_adj[48:16];
	assign rem       = total - $signed({whole, 16'd0});

	// saturating add into the pending count
	assign sat_hi = SW'({1'b0, {(COUNT_WIDTH-1){1'b1}}});
	assign sat_lo = ~sat_hi;
	assign pend_x = SW'(pending_q);
	assign addend = (mid.op == OP_STEPS) ? SW'(mid.step_delta) : SW'(whole);
	assign sum    = pend_x + addend;

	always_comb begin
		if (sum > sat_hi)
			pending_sat = sat_hi[COUNT_WIDTH-1:0];
		else if (sum < sat_lo)
			pending_sat = sat_lo[COUNT_WIDTH-1:0];
		else
			pending_sat = sum[COUNT_WIDTH-1:0];
	end

	// tick: an interval beyond the timer range is met only at timer saturation
	assign el_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
	assign due    = (pending_q != '0) &&
		((LW'(el_inc) >= LW'(cfg.interval_ticks)) || (&el_inc));
	assign mag    = pending_q[COUNT_WIDTH-1] ? COUNT_WIDTH'(-pending_q)
		: COUNT_WIDTH'(pending_q);
	assign burst  = (cfg.burst_limit == 8'd0) ? 8'd1 : cfg.burst_limit;
	assign k      = (mag < COUNT_WIDTH'(burst)) ? mag[7:0] : burst;
	assign pending_tick = pending_q[COUNT_WIDTH-1]
		? pending_q + $signed(COUNT_WIDTH'(k))
		: pending_q - $signed(COUNT_WIDTH'(k));

	always_comb begin
		pending_d = pending_q;
		carry_d   = carry_q;
		dir_d     = dir_q;
		elapsed_d = elapsed_q;
		pulses_d  = 8'd0;
		case (mid.op)
			OP_TICK: begin
				elapsed_d = el_inc;
				if (due) begin
					dir_d     = !pending_q[COUNT_WIDTH-1];
					pending_d = pending_tick;
					pulses_d  = k;
					elapsed_d = '0;
				end
			end
			OP_STEPS: pending_d = pending_sat;
			OP_ANGLE: begin
				pending_d = pending_sat;
				carry_d   = rem[CARRY_W-1:0];
			end
			default: ;
		endcase
	end

	assign pend64 = 64'(pending_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			carry_q     <= '0;
			dir_q       <= 1'b1;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mid_take) begin
				pending_q   <= pending_d;
				carry_q     <= carry_d;
				dir_q       <= dir_d;
				elapsed_q   <= elapsed_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mid_take) begin
			out_q.pulses        <= pulses_d;
			out_q.dir_positive  <= dir_d;
			out_q.pending_steps <= pend64[31:0];
			out_q.mode_pins     <= decode_mode(cfg.microstep_mode);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: src/stepper_step_dir_generator.sv
// channel   direction  handshake              word
// in        input      in_valid / in_ready    in_data   (op, step_delta, angle_q16)
// out       output     out_valid / out_ready  out_data  (pulses, dir, pending, mode pins)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while out is ready; each input passes through these registers in order:
// input register, then the angle multiplier register, then state update into the result.
// State advances only when the result register can take the word, so stalls on out
// back up through the two stages; bubbles are squeezed out. cfg is always ready.
// Reset clears pending, carry and timer, sets direction positive and loads register defaults.
module stepper_step_dir_generator import sdg_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t cfg;
	logic mid_valid, mid_take;
	mid_t mid;

	sdg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdg_mult u_mult (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_data          (in_data),
		.steps_per_radian (cfg.steps_per_radian),
		.mid_take         (mid_take),
		.mid_valid        (mid_valid),
		.mid              (mid)
	);

	sdg_core #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_valid (mid_valid),
		.mid       (mid),
		.mid_take  (mid_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
